// File: rtl/kps_pkg.sv
// shared types and constants for the keypad scan block
`timescale 1ns / 1ps

package kps_pkg;

  localparam int KeyCount = 10;
  localparam int CntW = 6;
  localparam int FramesW = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW = 16;
  localparam int OutDataW = 56;

  localparam logic [CntW-1:0] StartDelay = CntW'(40);
  localparam logic [CntW-1:0] ContinueDelay = CntW'(5);

  localparam logic [KeyCount-1:0] KeyA = KeyCount'(1);
  localparam int KeyLBit = 9;

  localparam logic [1:0] ModeRemapLToA = 2'd2;

  localparam int FlagForce = 0;
  localparam int FlagIgnore = 1;
  localparam int FlagChord = 2;

  localparam logic [CfgIdxW-1:0] RegKeyFlags = 3'd0;
  localparam logic [CfgIdxW-1:0] RegForceMask = 3'd1;
  localparam logic [CfgIdxW-1:0] RegForceFrames = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIgnoreMask = 3'd3;
  localparam logic [CfgIdxW-1:0] RegChordKeys = 3'd4;
  localparam logic [CfgIdxW-1:0] RegButtonMode = 3'd5;
  localparam logic [CfgIdxW-1:0] RegWatchedMask = 3'd6;

  typedef logic [KeyCount-1:0] keys_t;

  typedef struct packed {
    logic [2:0]         key_flags;
    keys_t              force_mask;
    logic               force_load;
    logic [FramesW-1:0] force_frames;
    keys_t              ignore_mask;
    keys_t              chord_keys;
    logic [1:0]         button_mode;
    keys_t              watched_mask;
  } cfg_t;

  typedef struct packed {
    logic  script_trigger;
    logic  watched_hit;
    keys_t held_keys_raw;
    keys_t repeat_keys;
    keys_t held_keys;
    keys_t new_keys;
    keys_t new_keys_raw;
  } result_t;

endpackage

// File: rtl/kps_cfg_regs.sv
// configuration register file of the keypad scan block
`timescale 1ns / 1ps

module kps_cfg_regs import kps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [2:0]         key_flags_q;
  keys_t              force_mask_q;
  logic [FramesW-1:0] force_frames_q;
  keys_t              ignore_mask_q;
  keys_t              chord_keys_q;
  logic [1:0]         button_mode_q;
  keys_t              watched_mask_q;
  logic               force_load_q;
  logic               wr;

  assign cfg_ready_o = 1'b1;
  assign wr = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_flags_q    <= '0;
      force_mask_q   <= '0;
      force_frames_q <= '0;
      ignore_mask_q  <= '0;
      chord_keys_q   <= '0;
      button_mode_q  <= '0;
      watched_mask_q <= '0;
      force_load_q   <= 1'b0;
    end else begin
      force_load_q <= 1'b0;
      if (wr) begin
        case (cfg_index_i)
          RegKeyFlags:    key_flags_q <= cfg_data_i[2:0];
          RegForceMask:   force_mask_q <= cfg_data_i[KeyCount-1:0];
          RegForceFrames: begin
            force_frames_q <= cfg_data_i[FramesW-1:0];
            force_load_q   <= 1'b1;
          end
          RegIgnoreMask:  ignore_mask_q <= cfg_data_i[KeyCount-1:0];
          RegChordKeys:   chord_keys_q <= cfg_data_i[KeyCount-1:0];
          RegButtonMode:  button_mode_q <= cfg_data_i[1:0];
          RegWatchedMask: watched_mask_q <= cfg_data_i[KeyCount-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg_o.key_flags    = key_flags_q;
    cfg_o.force_mask   = force_mask_q;
    cfg_o.force_load   = force_load_q;
    cfg_o.force_frames = force_frames_q;
    cfg_o.ignore_mask  = ignore_mask_q;
    cfg_o.chord_keys   = chord_keys_q;
    cfg_o.button_mode  = button_mode_q;
    cfg_o.watched_mask = watched_mask_q;
  end

endmodule

// File: rtl/kps_core.sv
// sample register, key state update and result register
`timescale 1ns / 1ps

module kps_core import kps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  keys_t   raw_keys_i,
  input  logic    script_busy_i,
  input  logic    overworld_idle_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic               s1_valid_q, s1_valid_d;
  keys_t              s1_keys_q;
  logic               s1_busy_q, s1_idle_q;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, res;
  keys_t              prev_held_q, prev_held_d;
  logic [CntW-1:0]    rep_cnt_q, rep_cnt_d;
  logic [FramesW-1:0] force_rem_q, force_rem_d;
  logic [FramesW-1:0] force_eff;
  logic               in_xfer, s1_adv, out_free;
  logic               force_act;
  keys_t              sample, held, fresh, rep, new_m, held_m;
  logic [CntW-1:0]    cnt_dec;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    // a fresh force_frames write takes effect in the cycle right after it
    force_eff = cfg_i.force_load ? cfg_i.force_frames : force_rem_q;
    force_act = cfg_i.key_flags[FlagForce] && (force_eff != '0);
    sample = s1_keys_q;
    if (force_act) begin
      sample = sample & ~cfg_i.force_mask;
    end
    if (cfg_i.key_flags[FlagIgnore]) begin
      sample = sample | cfg_i.ignore_mask;
    end
    held  = ~sample;
    fresh = held & ~prev_held_q;
    rep   = fresh;
    cnt_dec = rep_cnt_q - CntW'(1);

    rep_cnt_d   = rep_cnt_q;
    prev_held_d = prev_held_q;
    force_rem_d = force_eff;
    if (s1_adv) begin
      prev_held_d = held;
      if (force_act) begin
        force_rem_d = force_eff - FramesW'(1);
      end
      if (held != '0 && held == prev_held_q) begin
        if (cnt_dec == '0) begin
          rep       = held;
          rep_cnt_d = ContinueDelay;
        end else begin
          rep_cnt_d = cnt_dec;
        end
      end else begin
        rep_cnt_d = StartDelay;
      end
    end

    new_m  = fresh;
    held_m = held;
    if (cfg_i.button_mode == ModeRemapLToA) begin
      if (new_m[KeyLBit]) new_m = new_m | KeyA;
      if (held_m[KeyLBit]) held_m = held_m | KeyA;
    end

    res.new_keys_raw   = fresh;
    res.new_keys       = new_m;
    res.held_keys      = held_m;
    res.repeat_keys    = rep;
    res.held_keys_raw  = held;
    res.watched_hit    = (new_m & cfg_i.watched_mask) != '0;
    res.script_trigger = cfg_i.key_flags[FlagChord] && !s1_busy_q && s1_idle_q &&
                         ((cfg_i.chord_keys & s1_keys_q) == '0);

    s1_valid_d  = in_xfer || (s1_valid_q && !s1_adv);
    out_valid_d = s1_adv || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_held_q <= '0;
      rep_cnt_q   <= StartDelay;
      force_rem_q <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      prev_held_q <= prev_held_d;
      rep_cnt_q   <= rep_cnt_d;
      force_rem_q <= force_rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_keys_q <= raw_keys_i;
      s1_busy_q <= script_busy_i;
      s1_idle_q <= overworld_idle_i;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_cnt_q != '0)
    else $error("repeat counter reached zero");

  a_fresh_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.new_keys_raw & ~out_q.held_keys_raw) == '0))
    else $error("new key not in held set");

  a_prev_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (prev_held_q == out_q.held_keys_raw))
    else $error("previous held set not updated");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with free stage");

endmodule

// File: rtl/keypad_scan_with_autorepeat.sv
// top level of the keypad scan block with autorepeat
`timescale 1ns / 1ps

// Takes one active-low key sample per transfer and returns one result per
// sample. A sample lands in an input register, the key logic works on it
// combinationally and writes the result register, so a new sample is taken
// every clock cycle unless the receiver holds results back. The result
// register lets the next sample be taken while a result waits. Register
// writes apply at once and are meant to be made while no sample is in flight.
module keypad_scan_with_autorepeat import kps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // raw_keys[9:0], script_busy[10], overworld_idle[11], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // new_keys_raw[9:0], new_keys[19:10], held_keys[29:20], repeat_keys[39:30],
  // held_keys_raw[49:40], watched_hit[50], script_trigger[51], zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  result_t res;

  kps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kps_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .raw_keys_i       (s_axis_tdata[KeyCount-1:0]),
    .script_busy_i    (s_axis_tdata[KeyCount]),
    .overworld_idle_i (s_axis_tdata[KeyCount+1]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_o            (res)
  );

  assign m_axis_tdata = {{(OutDataW - $bits(result_t)){1'b0}}, res};

endmodule

// File: dv/tb_keypad_scan_with_autorepeat.sv
// testbench for keypad_scan_with_autorepeat: directed and random frames checked against a predictor
`timescale 1ns / 1ps

module tb_keypad_scan_with_autorepeat;
  import kps_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam logic [1:0] ModeOne = 2'd1;
  localparam logic [1:0] ModeThree = 2'd3;
  localparam keys_t NoKeys = '0;
  localparam keys_t AllKeys = '1;
  localparam keys_t KeyL = keys_t'(1) << KeyLBit;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // predictor state and register copies
  keys_t              scan_prev_held = '0;
  logic [CntW-1:0]    scan_repeat_cnt = StartDelay;
  logic [FramesW-1:0] scan_force_left = '0;
  logic [2:0]         reg_key_flags = '0;
  keys_t              reg_force_mask = '0;
  keys_t              reg_ignore_mask = '0;
  keys_t              reg_chord_keys = '0;
  logic [1:0]         reg_button_mode = '0;
  keys_t              reg_watched_mask = '0;

  result_t expected_frames[$];
  int      mismatch_cnt = 0;
  int      results_seen = 0;
  bit      gaps_on = 1'b1;
  logic    rx_hold = 1'b0;
  int      rx_stall_left = 0;
  int      rx_gap;
  event    hold_kick;

  keypad_scan_with_autorepeat i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic result_t predict_scan(keys_t raw, logic busy, logic idle);
    result_t r;
    keys_t   smp;
    keys_t   held;
    keys_t   fresh;
    keys_t   rpt;
    r.script_trigger = reg_key_flags[FlagChord] && !busy && idle
                       && ((reg_chord_keys & raw) == NoKeys);
    smp = raw;
    if (reg_key_flags[FlagForce] && scan_force_left != 0) begin
      scan_force_left = scan_force_left - 1'b1;
      smp = smp & ~reg_force_mask;
    end
    if (reg_key_flags[FlagIgnore]) smp = smp | reg_ignore_mask;
    held = ~smp;
    fresh = held & ~scan_prev_held;
    rpt = fresh;
    if (held != NoKeys && held == scan_prev_held) begin
      scan_repeat_cnt = scan_repeat_cnt - 1'b1;
      if (scan_repeat_cnt == 0) begin
        rpt = held;
        scan_repeat_cnt = ContinueDelay;
      end
    end else begin
      scan_repeat_cnt = StartDelay;
    end
    scan_prev_held = held;
    r.new_keys_raw = fresh;
    r.held_keys_raw = held;
    r.repeat_keys = rpt;
    r.new_keys = fresh;
    r.held_keys = held;
    if (reg_button_mode == ModeRemapLToA) begin
      if (fresh[KeyLBit]) r.new_keys = r.new_keys | KeyA;
      if (held[KeyLBit]) r.held_keys = r.held_keys | KeyA;
    end
    r.watched_hit = (r.new_keys & reg_watched_mask) != NoKeys;
    return r;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      RegKeyFlags:    reg_key_flags = data[2:0];
      RegForceMask:   reg_force_mask = data[KeyCount-1:0];
      RegForceFrames: scan_force_left = data[FramesW-1:0];
      RegIgnoreMask:  reg_ignore_mask = data[KeyCount-1:0];
      RegChordKeys:   reg_chord_keys = data[KeyCount-1:0];
      RegButtonMode:  reg_button_mode = data[1:0];
      RegWatchedMask: reg_watched_mask = data[KeyCount-1:0];
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("error at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) note_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  task automatic check_result(input logic [OutDataW-1:0] data);
    result_t got;
    result_t want;
    got = data[$bits(result_t)-1:0];
    results_seen++;
    if (expected_frames.size() == 0) begin
      note_mismatch($sformatf("result %0h with nothing pending", data));
      return;
    end
    want = expected_frames.pop_front();
    check_field("new_keys_raw", want.new_keys_raw, got.new_keys_raw);
    check_field("new_keys", want.new_keys, got.new_keys);
    check_field("held_keys", want.held_keys, got.held_keys);
    check_field("repeat_keys", want.repeat_keys, got.repeat_keys);
    check_field("held_keys_raw", want.held_keys_raw, got.held_keys_raw);
    check_field("watched_hit", want.watched_hit, got.watched_hit);
    check_field("script_trigger", want.script_trigger, got.script_trigger);
  endtask

  // result side: check each transfer, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      rx_gap = pick_gap();
      rx_stall_left <= (rx_gap > 0) ? rx_gap - 1 : 0;
      m_axis_tready <= (rx_gap == 0);
    end
  end

  // long receiver hold-off
  always begin
    @(hold_kick);
    rx_hold <= 1'b1;
    repeat (200) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic send_frame(input keys_t raw, input logic busy, input logic idle);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, idle, busy, raw};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_frames.push_back(predict_scan(raw, busy, idle));
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain(input int settle);
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    send_frame(AllKeys, 1'b0, 1'b0);
    send_frame(NoKeys, 1'b1, 1'b1);
    send_frame(NoKeys, 1'b0, 1'b1);
    send_frame(AllKeys, 1'b1, 1'b0);
  endtask

  task automatic test_forcing();
    drain(4);
    cfg_write(RegKeyFlags, 16'(1 << FlagForce));
    cfg_write(RegForceMask, 16'h03FF);
    cfg_write(RegForceFrames, 16'd3);
    repeat (4) send_frame(AllKeys, 1'b0, 1'b0);
  endtask

  task automatic test_ignoring();
    drain(4);
    cfg_write(RegKeyFlags, 16'((1 << FlagIgnore) | (1 << FlagForce)));
    cfg_write(RegIgnoreMask, 16'h02AA);
    cfg_write(RegForceMask, 16'h00F0);
    cfg_write(RegForceFrames, 16'd1);
    send_frame(AllKeys, 1'b0, 1'b0);
    send_frame(NoKeys, 1'b0, 1'b0);
  endtask

  task automatic test_remap();
    drain(4);
    cfg_write(RegKeyFlags, 16'd0);
    cfg_write(RegButtonMode, 16'(ModeRemapLToA));
    cfg_write(RegWatchedMask, 16'(KeyA));
    cfg_write(RegUnused, 16'hFFFF);
    send_frame(AllKeys, 1'b0, 1'b0);
    send_frame(~KeyL, 1'b0, 1'b0);
    send_frame(~KeyL, 1'b0, 1'b0);
    send_frame(AllKeys, 1'b0, 1'b0);
    send_frame(~(KeyL | KeyA), 1'b0, 1'b0);
    drain(4);
    cfg_write(RegButtonMode, 16'(ModeThree));
    send_frame(AllKeys, 1'b0, 1'b0);
    send_frame(~KeyL, 1'b0, 1'b0);
  endtask

  task automatic test_chord_trigger();
    drain(4);
    cfg_write(RegKeyFlags, 16'(1 << FlagChord));
    cfg_write(RegChordKeys, 16'd0);
    cfg_write(RegButtonMode, 16'(ModeOne));
    send_frame(AllKeys, 1'b0, 1'b0);
    send_frame(AllKeys, 1'b0, 1'b1);
    send_frame(AllKeys, 1'b1, 1'b1);
    send_frame(AllKeys, 1'b1, 1'b0);
    drain(4);
    cfg_write(RegChordKeys, 16'h0003);
    send_frame(~keys_t'(10'h003), 1'b0, 1'b1);
    send_frame(~keys_t'(10'h001), 1'b0, 1'b1);
  endtask

  task automatic test_backpressure();
    drain(4);
    cfg_write(RegKeyFlags, 16'd0);
    cfg_write(RegButtonMode, 16'(ModeRemapLToA));
    gaps_on = 1'b0;
    -> hold_kick;
    repeat (46) send_frame(~(KeyL | keys_t'(10'h002)), 1'b0, 1'b1);
    gaps_on = 1'b1;
  endtask

  task automatic load_setup(input int kind);
    logic [CfgDataW-1:0] v[7];
    for (int i = 0; i < 7; i++) begin
      v[i] = (kind == 0) ? 16'hFFFF : (kind == 1) ? 16'h0000 : 16'($urandom);
    end
    if (kind > 1) begin
      v[RegForceMask] = v[RegForceMask] & 16'($urandom);
      v[RegForceFrames] = 16'($urandom_range(0, 20));
      v[RegIgnoreMask] = v[RegIgnoreMask] & 16'($urandom) & 16'($urandom);
      case ($urandom_range(0, 2))
        0: v[RegChordKeys] = 16'd0;
        1: v[RegChordKeys] = 16'(1 << $urandom_range(0, KeyCount - 1));
        default: v[RegChordKeys] = 16'((1 << $urandom_range(0, KeyCount - 1))
                                       | (1 << $urandom_range(0, KeyCount - 1)));
      endcase
    end
    cfg_write(RegKeyFlags, v[RegKeyFlags]);
    cfg_write(RegForceMask, v[RegForceMask]);
    cfg_write(RegForceFrames, v[RegForceFrames]);
    cfg_write(RegIgnoreMask, v[RegIgnoreMask]);
    cfg_write(RegChordKeys, v[RegChordKeys]);
    cfg_write(RegButtonMode, v[RegButtonMode]);
    cfg_write(RegWatchedMask, v[RegWatchedMask]);
  endtask

  task automatic run_random_frames(input int n);
    int    sent;
    int    hold_len;
    keys_t pressed;
    logic  busy;
    logic  idle;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 4) == 0) begin
        send_frame(keys_t'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0: pressed = NoKeys;
          1: pressed = keys_t'(1) << $urandom_range(0, KeyCount - 1);
          2: pressed = reg_chord_keys | (keys_t'($urandom) & keys_t'($urandom));
          default: pressed = keys_t'($urandom);
        endcase
        hold_len = ($urandom_range(0, 5) == 0) ? $urandom_range(38, 60) : $urandom_range(1, 6);
        busy = ($urandom_range(0, 3) == 0);
        idle = ($urandom_range(0, 3) != 0);
        repeat (hold_len) begin
          send_frame(~pressed, busy, idle);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 9; ph++) begin
      drain(4);
      load_setup(ph);
      gaps_on = (ph % 3 != 2);
      run_random_frames(100);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_forcing();
    test_ignoring();
    test_remap();
    test_chord_trigger();
    test_backpressure();
    test_random();
    drain(10);
    if (mismatch_cnt == 0 && expected_frames.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
rtl/kps_pkg.sv
rtl/kps_cfg_regs.sv
rtl/kps_core.sv
rtl/keypad_scan_with_autorepeat.sv
dv/tb_keypad_scan_with_autorepeat.sv
